FILE: design/clm_pkg.sv
// ----------------------------------------------------------------------------
// clm_pkg
// Shared types and constants of the CPU load meter.
// ----------------------------------------------------------------------------
package clm_pkg;

  localparam int unsigned CNT_W      = 33;  // window counters, never wrap
  localparam int unsigned ALU_W      = 44;  // holds 1000 * idle_count
  localparam int unsigned LOAD_W     = 10;
  localparam int unsigned WIN_W      = 32;
  localparam int unsigned BIT_IDX_W  = 4;
  localparam logic [BIT_IDX_W-1:0] DIV_TOP_BIT = 4'd9;
  localparam logic [LOAD_W-1:0]    PERMILLE_FULL = 10'd1000;
  localparam logic [WIN_W-1:0]     WINDOW_RESET  = 32'd1000000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_T,
    S_ADD_I,
    S_CMP,
    S_MUL0,
    S_MUL1,
    S_DIV,
    S_FIN,
    S_OUT
  } clm_state_t;

  typedef struct packed {
    clm_state_t             state;
    logic [BIT_IDX_W-1:0]   bit_idx;
  } clm_ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic out_fire;
    logic idle_flag;
    logic alu_carry;
  } clm_status_t;

endpackage

FILE: design/clm_alu.sv
// ----------------------------------------------------------------------------
// clm_alu
// Shared add/subtract unit; carry out is set on subtract when a >= b.
// ----------------------------------------------------------------------------
module clm_alu (
  input  logic [clm_pkg::ALU_W-1:0] a,
  input  logic [clm_pkg::ALU_W-1:0] b,
  input  logic                      sub,
  output logic [clm_pkg::ALU_W-1:0] res,
  output logic                      carry
);
  import clm_pkg::*;

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   sum;

  assign b_op = sub ? ~b : b;
  assign sum  = {1'b0, a} + {1'b0, b_op} + {{ALU_W{1'b0}}, sub};
  assign res   = sum[ALU_W-1:0];
  assign carry = sum[ALU_W];

endmodule

FILE: design/clm_seq.sv
// ----------------------------------------------------------------------------
// clm_seq
// Step sequencer: accumulate, window compare, multiply, divide, deliver.
// ----------------------------------------------------------------------------
module clm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clm_pkg::clm_status_t status,
  output clm_pkg::clm_ctrl_t   ctrl
);
  import clm_pkg::*;

  clm_state_t           state_r, state_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (status.in_fire) state_nxt = S_ADD_T;
      S_ADD_T: state_nxt = status.idle_flag ? S_ADD_I : S_CMP;
      S_ADD_I: state_nxt = S_CMP;
      S_CMP:   state_nxt = status.alu_carry ? S_OUT : S_MUL0;
      S_MUL0:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_DIV;
      S_DIV:   if (bit_r == '0) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (status.out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and quotient bit counter
  always_comb begin
    bit_nxt = bit_r;
    case (state_r)
      S_MUL1:  bit_nxt = DIV_TOP_BIT;
      S_DIV:   bit_nxt = bit_r - 1'b1;
      default: bit_nxt = bit_r;
    endcase
    ctrl.state   = state_r;
    ctrl.bit_idx = bit_r;
  end

endmodule

FILE: design/cpu_load_meter_core.sv
// ----------------------------------------------------------------------------
// cpu_load_meter_core
// CPU load meter in permille, built around one shared add/subtract unit.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------
//  in_     | slave     | tdata: interval_ticks; tuser: interval_was_idle
//  out_    | master    | tdata: load_permille; tuser: load_updated
//  cfg_    | slave     | data: window_ticks (always ready)
//
//  An item that does not close the window goes through the total add, the
//  idle add for an idle item only, and the window compare before its result
//  is offered. One that closes it also goes through the two multiply steps,
//  the ten restoring divide steps and the final subtract on the shared
//  44-bit adder. The result waits in its register until taken; in_tready
//  stays low until then, so no new item is taken while one is in progress.
//  Reset (rst_n low, synchronous) clears the counters and load and sets
//  window_ticks to 1000000.
//
module cpu_load_meter_core #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] interval_ticks
  input  logic        in_tuser,    // [0] interval_was_idle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [9:0] load_permille, [15:10] zero
  output logic        out_tuser,   // [0] load_updated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data     // [31:0] window_ticks
);
  import clm_pkg::*;

  // ticks keep only their low TICK_BITS bits
  localparam int unsigned DT_W = (TICK_BITS < 32) ? TICK_BITS : 32;

  clm_ctrl_t   ctrl;
  clm_status_t status;

  logic [WIN_W-1:0]  window_r;
  logic [DT_W-1:0]   dt_r;
  logic              idle_r;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  idlec_r;
  logic [ALU_W-1:0]  num_r;
  logic [LOAD_W-1:0] q_r;
  logic [LOAD_W-1:0] load_r;
  logic              upd_r;

  logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_sub, alu_carry;
  logic [ALU_W-1:0]  total_ext, idlec_ext, dt_ext;

  assign in_tready  = (ctrl.state == S_IDLE);
  assign out_tvalid = (ctrl.state == S_OUT);
  assign out_tdata  = {{(16-LOAD_W){1'b0}}, load_r};
  assign out_tuser  = upd_r;
  assign cfg_ready  = 1'b1;

  assign status.in_fire   = in_tvalid & in_tready;
  assign status.out_fire  = out_tvalid & out_tready;
  assign status.idle_flag = idle_r;
  assign status.alu_carry = alu_carry;

  assign total_ext = {{(ALU_W-CNT_W){1'b0}}, total_r};
  assign idlec_ext = {{(ALU_W-CNT_W){1'b0}}, idlec_r};
  assign dt_ext    = {{(ALU_W-DT_W){1'b0}}, dt_r};

  clm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  clm_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  // route operands to the shared adder for each step
  always_comb begin
    alu_a   = total_ext;
    alu_b   = dt_ext;
    alu_sub = 1'b0;
    case (ctrl.state)
      S_ADD_T: begin
        alu_a = total_ext;
        alu_b = dt_ext;
      end
      S_ADD_I: begin
        alu_a = idlec_ext;
        alu_b = dt_ext;
      end
      S_CMP: begin
        // no borrow means total <= window: window stays open
        alu_a   = {{(ALU_W-WIN_W){1'b0}}, window_r};
        alu_b   = total_ext;
        alu_sub = 1'b1;
      end
      S_MUL0: begin
        // 1000 * idle = (idle << 10) - (idle << 4) - (idle << 3)
        alu_a   = idlec_ext << 10;
        alu_b   = idlec_ext << 4;
        alu_sub = 1'b1;
      end
      S_MUL1: begin
        alu_a   = num_r;
        alu_b   = idlec_ext << 3;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        // restoring step against total shifted to the current quotient bit
        alu_a   = num_r;
        alu_b   = total_ext << ctrl.bit_idx;
        alu_sub = 1'b1;
      end
      S_FIN: begin
        alu_a   = {{(ALU_W-LOAD_W){1'b0}}, PERMILLE_FULL};
        alu_b   = {{(ALU_W-LOAD_W){1'b0}}, q_r};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = total_ext;
        alu_b   = dt_ext;
        alu_sub = 1'b0;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      total_r  <= '0;
      idlec_r  <= '0;
      load_r   <= '0;
      upd_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_data;
      end
      case (ctrl.state)
        S_ADD_T: total_r <= alu_res[CNT_W-1:0];
        S_ADD_I: idlec_r <= alu_res[CNT_W-1:0];
        S_CMP:   upd_r   <= 1'b0;
        S_FIN: begin
          load_r  <= alu_res[LOAD_W-1:0];
          upd_r   <= 1'b1;
          total_r <= '0;
          idlec_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (status.in_fire) begin
      dt_r   <= in_tdata[DT_W-1:0];
      idle_r <= in_tuser;
    end
    case (ctrl.state)
      S_MUL0: begin
        num_r <= alu_res;
        q_r   <= '0;
      end
      S_MUL1: num_r <= alu_res;
      S_DIV: begin
        if (alu_carry) begin
          num_r <= alu_res;
        end
        q_r[ctrl.bit_idx] <= alu_carry;
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/tb_cpu_load_meter_core.sv
// ----------------------------------------------------------------------------
// tb_cpu_load_meter_core
// Self-checking bench for the CPU load meter: drives context-switch items,
// predicts every load result in a scoreboard and compares each returned item.
// ----------------------------------------------------------------------------
module tb_cpu_load_meter_core;
  import clm_pkg::*;

  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 95;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned REPORT_LIMIT  = 10;

  // one expected result item: tdata as driven on the bus, tuser flag
  typedef struct packed {
    logic [15:0] tdata;
    logic        tuser;
  } load_item_t;

  // Scoreboard: keeps its own copy of the window register and counters,
  // works out the load for every accepted item, checks items in order.
  class load_ledger;
    logic [WIN_W-1:0]  window;
    logic [CNT_W-1:0]  total_ticks;
    logic [CNT_W-1:0]  idle_ticks;
    logic [LOAD_W-1:0] load;
    load_item_t        expected_loads[$];
    int unsigned       errors;

    function new();
      window      = WINDOW_RESET;
      total_ticks = '0;
      idle_ticks  = '0;
      load        = '0;
      errors      = 0;
    endfunction

    function void set_window(logic [WIN_W-1:0] value);
      window = value;
    endfunction

    function int unsigned pending();
      return expected_loads.size();
    endfunction

    function void note_event(logic [31:0] ticks, logic was_idle);
      logic [ALU_W-1:0] scaled;
      logic [ALU_W-1:0] ratio;
      load_item_t       item;
      item.tuser  = 1'b0;
      total_ticks = total_ticks + CNT_W'(ticks);
      if (was_idle) begin
        idle_ticks = idle_ticks + CNT_W'(ticks);
      end
      // close the window once the total is strictly above the register
      if (total_ticks > CNT_W'(window)) begin
        scaled = ALU_W'(idle_ticks) * ALU_W'(PERMILLE_FULL);
        ratio  = scaled / ALU_W'(total_ticks);
        if (ratio > ALU_W'(PERMILLE_FULL)) begin
          ratio = ALU_W'(PERMILLE_FULL);
        end
        load        = PERMILLE_FULL - ratio[LOAD_W-1:0];
        total_ticks = '0;
        idle_ticks  = '0;
        item.tuser  = 1'b1;
      end
      item.tdata = 16'(load);
      expected_loads.push_back(item);
    endfunction

    function void check_result(logic [15:0] tdata, logic tuser);
      load_item_t want;
      if (expected_loads.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("unexpected result item: load %0d updated %b pad %h",
                   tdata[9:0], tuser, tdata[15:10]);
        end
        return;
      end
      want = expected_loads.pop_front();
      if (tdata[9:0] !== want.tdata[9:0] || tdata[15:10] !== want.tdata[15:10] ||
          tuser !== want.tuser) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("result mismatch: load exp %0d got %0d, updated exp %b got %b, pad got %h",
                   want.tdata[9:0], tdata[9:0], want.tuser, tuser, tdata[15:10]);
        end
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] interval_ticks
  logic        in_tuser   = 1'b0; // [0] interval_was_idle
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [9:0] load_permille, [15:10] zero
  logic        out_tuser;         // [0] load_updated
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data   = '0;   // [31:0] window_ticks

  // idling knobs, percent per cycle, and idle bias, percent of items; set by the main sequence per phase
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned idle_pct     = 50;
  // long receiver hold-off: bump hold_request to start one
  int unsigned hold_request = 0;
  int unsigned hold_taken   = 0;
  int unsigned hold_left    = 0;

  load_ledger ledger;

  cpu_load_meter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off for a long counted stretch so the
  // block fills up and drops in_tready while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_taken != hold_request) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= hold_request;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every result item taken at this edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      ledger.check_result(out_tdata, out_tuser);
    end
  end

  // Offer one item, idling first if the sender is in a gappy phase; note it
  // in the scoreboard at the edge that accepts it. tvalid stays high after.
  task automatic send_event(logic [31:0] ticks, logic was_idle);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ticks;
    in_tuser  <= was_idle;
    do @(posedge clk); while (!in_tready);
    ledger.note_event(ticks, was_idle);
  endtask

  // Stop offering and hold until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the window register; call only with the block drained.
  task automatic write_window(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.set_window(value);
  endtask

  // Ticks scaled to the window so windows close every few items, with some
  // zero-tick items and some full 32-bit values mixed in.
  function automatic logic [31:0] random_ticks(logic [31:0] window);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    span = window / 4 + 1;
    if (roll < 8) begin
      return $urandom;
    end
    if (roll < 16) begin
      return '0;
    end
    return $urandom_range(span, 0);
  endfunction

  initial begin
    logic [31:0] window;
    ledger = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset window first, then the register extremes.
    send_event(32'd0, 1'b0);          // zero-tick item, no close
    send_event(32'd1000000, 1'b1);    // total equals window, no close
    send_event(32'd1, 1'b0);          // one tick over closes the window
    send_event(32'hFFFF_FFFF, 1'b1);  // all idle: load zero
    send_event(32'hFFFF_FFFF, 1'b0);  // no idle: full load
    send_event(32'hAAAA_AAAA, 1'b1);
    send_event(32'h5555_5555, 1'b0);
    drain();
    write_window(32'd0);              // every nonzero tick closes
    send_event(32'd0, 1'b1);
    send_event(32'd1, 1'b1);
    send_event(32'd1, 1'b0);
    send_event(32'd0, 1'b0);
    drain();
    write_window(32'hFFFF_FFFF);      // widest total, widest product
    send_event(32'hFFFF_FFFF, 1'b1);
    send_event(32'hFFFF_FFFF, 1'b1);
    send_event(32'hFFFF_FFFF, 1'b1);
    send_event(32'hFFFF_FFFF, 1'b0);  // half idle
    drain();
    write_window(32'd1);
    send_event(32'd1, 1'b1);
    send_event(32'd1, 1'b0);

    // Random phases: new window, idling mode and idle bias each phase,
    // with a full drain between them.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       window = 32'd0;
        1:       window = $urandom_range(64, 1);
        2:       window = 32'd1000000;
        3:       window = 32'hFFFF_FFFF;
        4:       window = $urandom;
        5:       window = $urandom_range(5000, 100);
        6:       window = 32'd1;
        default: window = $urandom_range(32'h0010_0000, 0);
      endcase
      write_window(window);
      case (p % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 68; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 68; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      idle_pct = $urandom_range(100);
      if (p == 1 || p == 4) begin
        hold_request = hold_request + 1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_event(random_ticks(window), $urandom_range(99) < idle_pct);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("cpu_load_meter_core: match");
    end else begin
      $display("cpu_load_meter_core: mismatch");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("cpu_load_meter_core: mismatch");
    $finish;
  end

endmodule

FILE: files.f
design/clm_pkg.sv
design/clm_alu.sv
design/clm_seq.sv
design/cpu_load_meter_core.sv
tb/tb_cpu_load_meter_core.sv
